// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is asserted.
`define TBP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define TBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/tbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

    // Two-bit saturating counter.
    typedef logic [1:0] t_ctr;

    localparam t_ctr CTR_MAX       = 2'd3;
    localparam t_ctr CTR_MIN       = 2'd0;
    localparam t_ctr CTR_TAKEN_MIN = 2'd2;

    // One resolved branch.
    typedef struct packed {
        logic [31:0] branch_address;
        logic        branch_taken;
    } t_branch;

    // One prediction report.
    typedef struct packed {
        logic predicted_taken;
        logic used_global;
        logic prediction_correct;
    } t_result;

    // Moves a counter one step up or down, saturating at both ends.
    function automatic t_ctr sat_step(t_ctr c, logic up);
        t_ctr r;
        r = c;
        if (up) begin
            if (c != CTR_MAX) r = c + 2'd1;
        end else begin
            if (c != CTR_MIN) r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tbp_branch_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tbp_branch_if;
    logic             valid;
    logic             ready;
    tbp_pkg::t_branch payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tbp_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tbp_result_if;
    logic             valid;
    logic             ready;
    tbp_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tournament_branch_predictor_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Tournament branch predictor (bimodal plus gshare, chosen per address). Each transfer on
// i_branch carries one resolved branch; exactly one transfer on o_result follows it, in order,
// reporting the direction predicted from the state before that branch, which component made
// the prediction and whether it was right. The block then trains both components, the chooser
// and the global history. It takes one branch per clock cycle when o_result is not stalled;
// a branch's report is registered as it leaves the update stage. Each table has a single
// read port: the counters are read in the cycle of the transfer, updated in the update
// stage and written back through the one write port, with a bypass for a branch that
// reads an entry the previous branch is writing in the same cycle. After reset the block runs
// a clearing pass that zeroes one entry of every table per cycle and holds i_branch.ready
// low until it is done.

module tournament_branch_predictor_core #(
    parameter int INDEX_BITS = 12
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    tbp_branch_if.sink       i_branch,
    tbp_result_if.source     o_result
);

    localparam int TABLE_DEPTH = 1 << INDEX_BITS;

    // Bimodal and chooser counters share an index, so they live in one memory word:
    // chooser in the upper two bits, bimodal in the lower two.
    logic [3:0] r_loc_mem [TABLE_DEPTH];
    logic [1:0] r_glb_mem [TABLE_DEPTH];

    // Clearing pass after reset.
    logic                  r_clr_busy;
    logic [INDEX_BITS-1:0] r_clr_idx;

    // Global outcome history, newest outcome in bit 0.
    logic [INDEX_BITS-1:0] r_hist;

    // Update stage: the branch whose counters have just been read.
    logic                  r_s1_valid;
    logic [INDEX_BITS-1:0] r_s1_bim_idx;
    logic [INDEX_BITS-1:0] r_s1_glb_idx;
    logic                  r_s1_taken;
    logic [3:0]            r_loc_rdata;
    logic [1:0]            r_glb_rdata;
    logic                  r_fwd_loc_hit;
    logic                  r_fwd_glb_hit;
    logic [3:0]            r_fwd_loc_data;
    logic [1:0]            r_fwd_glb_data;

    // Output register.
    logic             r_out_valid;
    tbp_pkg::t_result r_out_result;

    logic                  w_in_accept;
    logic                  w_s1_advance;
    logic [INDEX_BITS-1:0] w_bim_idx;
    logic [INDEX_BITS-1:0] w_glb_idx;

    logic [3:0]    w_loc_cur;
    logic [1:0]    w_glb_cur;
    tbp_pkg::t_ctr w_chooser;
    tbp_pkg::t_ctr w_bim;
    tbp_pkg::t_ctr w_comp;
    logic          w_use_global;
    logic          w_pred;
    logic          w_right;
    tbp_pkg::t_ctr n_chooser;
    tbp_pkg::t_ctr n_bim;
    tbp_pkg::t_ctr n_glb;

    logic                  w_loc_we;
    logic                  w_glb_we;
    logic [INDEX_BITS-1:0] w_loc_waddr;
    logic [INDEX_BITS-1:0] w_glb_waddr;
    logic [3:0]            w_loc_wdata;
    logic [1:0]            w_glb_wdata;

    // Handshakes. The update stage moves on whenever the output register is free or is being
    // emptied, so after clearing a new branch is taken each cycle the output is not stalled.
    assign w_s1_advance   = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_branch.ready = !r_clr_busy && (!r_s1_valid || w_s1_advance);
    assign w_in_accept    = i_branch.valid && i_branch.ready;

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out_result;

    // Table indices are formed from the history as it stands before this branch.
    assign w_bim_idx = i_branch.payload.branch_address[INDEX_BITS-1:0];
    assign w_glb_idx = w_bim_idx ^ r_hist;

    // Update stage: pick the freshest copy of each counter, predict, then train.
    always_comb begin
        w_loc_cur    = r_fwd_loc_hit ? r_fwd_loc_data : r_loc_rdata;
        w_glb_cur    = r_fwd_glb_hit ? r_fwd_glb_data : r_glb_rdata;
        w_chooser    = w_loc_cur[3:2];
        w_bim        = w_loc_cur[1:0];
        w_use_global = (w_chooser >= tbp_pkg::CTR_TAKEN_MIN);
        w_comp       = w_use_global ? w_glb_cur : w_bim;
        w_pred       = (w_comp >= tbp_pkg::CTR_TAKEN_MIN);
        w_right      = (w_pred == r_s1_taken);
        // Chooser steps up if the used side was gshare and right, or bimodal and wrong.
        n_chooser    = tbp_pkg::sat_step(w_chooser, w_use_global == w_right);
        n_bim        = tbp_pkg::sat_step(w_bim, r_s1_taken);
        n_glb        = tbp_pkg::sat_step(w_glb_cur, r_s1_taken);
    end

    // Write port: the clearing pass owns it after reset, the update stage afterwards.
    always_comb begin
        w_loc_we    = r_clr_busy || w_s1_advance;
        w_glb_we    = r_clr_busy || w_s1_advance;
        w_loc_waddr = r_clr_busy ? r_clr_idx : r_s1_bim_idx;
        w_glb_waddr = r_clr_busy ? r_clr_idx : r_s1_glb_idx;
        w_loc_wdata = r_clr_busy ? 4'd0 : {n_chooser, n_bim};
        w_glb_wdata = r_clr_busy ? 2'd0 : n_glb;
    end

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (w_loc_we) begin
            r_loc_mem[w_loc_waddr] <= w_loc_wdata;
        end
        if (w_in_accept) begin
            r_loc_rdata <= r_loc_mem[w_bim_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_glb_we) begin
            r_glb_mem[w_glb_waddr] <= w_glb_wdata;
        end
        if (w_in_accept) begin
            r_glb_rdata <= r_glb_mem[w_glb_idx];
        end
    end

    // Update-stage payload. The memory read in this cycle returns the old word, so when the
    // branch ahead writes the same entry right now, its new value is captured for bypass.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_bim_idx   <= w_bim_idx;
            r_s1_glb_idx   <= w_glb_idx;
            r_s1_taken     <= i_branch.payload.branch_taken;
            r_fwd_loc_hit  <= w_s1_advance && (r_s1_bim_idx == w_bim_idx);
            r_fwd_glb_hit  <= w_s1_advance && (r_s1_glb_idx == w_glb_idx);
            r_fwd_loc_data <= {n_chooser, n_bim};
            r_fwd_glb_data <= n_glb;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_s1_advance) begin
            r_out_result.predicted_taken    <= w_pred;
            r_out_result.used_global        <= w_use_global;
            r_out_result.prediction_correct <= w_right;
        end
    end

    // Control state and history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_hist      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + INDEX_BITS'(1);
                if (r_clr_idx == {INDEX_BITS{1'b1}}) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (w_in_accept) begin
                r_hist <= {r_hist[INDEX_BITS-2:0], i_branch.payload.branch_taken};
            end

            if (w_in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_advance) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tbp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tbp_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire i_pred,
    input wire i_used_global,
    input wire i_correct
);

    logic [1:0] r_inflight;
    logic [1:0] n_inflight;

    // Branches taken in whose reports have not yet been delivered.
    always_comb begin
        n_inflight = r_inflight;
        if (i_in_valid && i_in_ready) begin
            n_inflight = n_inflight + 2'd1;
        end
        if (i_out_valid && i_out_ready) begin
            n_inflight = n_inflight - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 2'd0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    `TBP_ASSERT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> !i_in_ready, "branch taken during clearing pass")
    `TBP_ASSERT_RST(a_hold_stalled, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pred) && $stable(i_used_global) && $stable(i_correct), "stalled report changed")
    `TBP_ASSERT_RST(a_depth_bound, i_clk, i_rst_n, r_inflight != 2'd3, "more than two branches in flight")
    `TBP_ASSERT_RST(a_no_orphan, i_clk, i_rst_n, i_out_valid |-> r_inflight != 2'd0, "report without a branch")

endmodule

bind tournament_branch_predictor_core tbp_checker u_tbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_branch.valid),
    .i_in_ready    (i_branch.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_pred        (o_result.payload.predicted_taken),
    .i_used_global (o_result.payload.used_global),
    .i_correct     (o_result.payload.prediction_correct)
);

`default_nettype wire
